@@ hdl/mrwt_pkg.sv @@
`timescale 1ns / 1ps

package mrwt_pkg;

  // Widths of the item fields on the channels.
  localparam int CAND_WIDTH    = 32;
  localparam int WIT_WIDTH     = 32;
  localparam int VERDICT_WIDTH = 2;

  // Verdict codes carried by a result item.
  typedef enum logic [VERDICT_WIDTH-1:0] {
    VERDICT_PRIME     = 2'd0,
    VERDICT_COMPOSITE = 2'd1,
    VERDICT_TRIVIAL   = 2'd2,
    VERDICT_BAD_WIT   = 2'd3
  } verdict_t;

  // Operand pairing for the shared modular multiplier.
  typedef enum logic [1:0] {
    MUL_ACC_SQ  = 2'd0,
    MUL_SQ_SQ   = 2'd1,
    MUL_ACC_ACC = 2'd2
  } mul_op_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SPLIT,
    S_EXP_BIT,
    S_WAIT_A,
    S_EXP_NEXT,
    S_WAIT_S,
    S_TEST_X,
    S_SQ_LOOP,
    S_WAIT_X,
    S_TEST_SQ,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     split_step;
    logic     pow_init;
    logic     mul_start;
    mul_op_t  mul_op;
    logic     e_shift;
    logic     k_dec;
    logic     verdict_we;
    verdict_t verdict;
    logic     emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;
    logic bad_wit;
    logic e_lsb;
    logic e_done;
    logic x_one;
    logic x_nm1;
    logic k_le1;
    logic mul_busy;
    logic out_free;
  } status_t;

endpackage

@@ hdl/mrwt_in_if.sv @@
`timescale 1ns / 1ps

interface mrwt_in_if import mrwt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CAND_WIDTH-1:0] candidate;
  logic [WIT_WIDTH-1:0]  witness;

  modport source (output valid, output candidate, output witness, input ready);
  modport sink (input valid, input candidate, input witness, output ready);
endinterface

@@ hdl/mrwt_out_if.sv @@
`timescale 1ns / 1ps

interface mrwt_out_if import mrwt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VERDICT_WIDTH-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

@@ hdl/miller_rabin_witness_test.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload                      Accepted when
// in_ch     input      candidate[31:0] witness[31:0] valid && ready
// out_ch    output     verdict[1:0]                 valid && ready
//
// One item at a time. Rejected items (trivial or bad witness) skip the multiplier.
// Otherwise n-1 is first split as s * 2^k, then each modular product is computed
// in the one shared multiply-and-reduce unit; an item needs up to about
// 2 * NUM_WIDTH products.
// Reset is synchronous; it clears the controller, the multiplier and the output valid.
// A new item is taken while a finished result still waits in the output register.

module miller_rabin_witness_test import mrwt_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input logic              clk,
  input logic              rst,
  mrwt_in_if.sink          in_ch,
  mrwt_out_if.source       out_ch
);

  cmd_t    cmd;
  status_t status;

  // Controller.
  mrwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath with the modular multiplier and output register.
  mrwt_dp #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .candidate (in_ch.candidate),
    .witness   (in_ch.witness),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .verdict   (out_ch.verdict)
  );

endmodule

@@ hdl/mrwt_dp.sv @@
`timescale 1ns / 1ps

module mrwt_dp import mrwt_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CAND_WIDTH-1:0]    candidate,
  input  logic [WIT_WIDTH-1:0]     witness,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VERDICT_WIDTH-1:0] verdict
);

  localparam int W       = NUM_WIDTH;
  localparam int K_WIDTH = $clog2(NUM_WIDTH);
  localparam int C_WIDTH = $clog2(NUM_WIDTH);

  // Operand registers of the current item.
  logic [W-1:0]       n;
  logic [W-1:0]       a;
  logic [W-1:0]       n_m1;
  logic [W-1:0]       e;
  logic [K_WIDTH-1:0] k;
  logic [W-1:0]       acc;
  logic [W-1:0]       sq;
  verdict_t           verdict_hold;
  verdict_t           verdict_out;

  // Modular multiplier state.
  logic               mul_busy;
  logic               mul_phase;
  mul_op_t            mul_op;
  logic [C_WIDTH-1:0] cnt;
  logic [W-1:0]       rem;
  logic [W-1:0]       lo;
  logic [W-1:0]       opa;
  logic [W-1:0]       opb;
  logic [2*W-1:0]     prod;
  logic [W:0]         trial;
  logic [W:0]         trial_sub;
  logic [W-1:0]       rem_next;
  logic               mul_last;

  assign n_m1 = n - W'(1);

  // Operand selection for the multiplier.
  always_comb begin
    case (mul_op)
      MUL_ACC_SQ: begin
        opa = acc;
        opb = sq;
      end
      MUL_SQ_SQ: begin
        opa = sq;
        opb = sq;
      end
      MUL_ACC_ACC: begin
        opa = acc;
        opb = acc;
      end
      default: begin
        opa = acc;
        opb = sq;
      end
    endcase
  end

  assign prod = {{W{1'b0}}, opa} * {{W{1'b0}}, opb};

  // One restoring reduction step: bring in the next product bit, subtract n if it fits.
  // Both operands are below n, so the high half already is, and each step stays below 2n.
  assign trial     = {rem, lo[W-1]};
  assign trial_sub = trial - {1'b0, n};
  assign rem_next  = (trial >= {1'b0, n}) ? trial_sub[W-1:0] : trial[W-1:0];
  assign mul_last  = mul_busy && mul_phase && (cnt == C_WIDTH'(W - 1));

  // Multiplier sequencing: a multiply step, then one reduction bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy  <= 1'b0;
      mul_phase <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy  <= 1'b1;
      mul_phase <= 1'b0;
    end else if (mul_busy && !mul_phase) begin
      mul_phase <= 1'b1;
    end else if (mul_last) begin
      mul_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_op <= cmd.mul_op;
    end
    if (mul_busy && !mul_phase) begin
      {rem, lo} <= prod;
      cnt       <= '0;
    end else if (mul_busy) begin
      rem <= rem_next;
      lo  <= {lo[W-2:0], 1'b0};
      cnt <= cnt + C_WIDTH'(1);
    end
  end

  // Item registers, exponent split and power accumulators.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= candidate[W-1:0];
      a <= witness[W-1:0];
      e <= candidate[W-1:0] - W'(1);
      k <= '0;
    end else if (cmd.split_step) begin
      e <= {1'b0, e[W-1:1]};
      k <= k + K_WIDTH'(1);
    end else begin
      if (cmd.e_shift) begin
        e <= {1'b0, e[W-1:1]};
      end
      if (cmd.k_dec) begin
        k <= k - K_WIDTH'(1);
      end
    end

    if (cmd.pow_init) begin
      acc <= W'(1);
      sq  <= a;
    end else if (mul_last) begin
      if (mul_op == MUL_SQ_SQ) begin
        sq <= rem_next;
      end else begin
        acc <= rem_next;
      end
    end

    if (cmd.verdict_we) begin
      verdict_hold <= cmd.verdict;
    end
  end

  // Output register for the result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      verdict_out <= verdict_hold;
    end
  end

  assign verdict = verdict_out;

  // Status toward the controller.
  always_comb begin
    status.trivial  = (n[W-1:1] == '0) || (!n[0] && (n != W'(2)));
    status.bad_wit  = (a == '0) || (a >= n);
    status.e_lsb    = e[0];
    status.e_done   = (e[W-1:1] == '0);
    status.x_one    = (acc == W'(1));
    status.x_nm1    = (acc == n_m1);
    status.k_le1    = (k[K_WIDTH-1:1] == '0);
    status.mul_busy = mul_busy;
    status.out_free = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  // The multiplier is never restarted while it is working.
  assert property (@(posedge clk) disable iff (rst) cmd.mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // Every finished product leaves both accumulators reduced below n.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(mul_busy)) |-> (acc < n && sq < n))
    else $error("modular product not reduced");
`endif

endmodule

@@ hdl/mrwt_ctrl.sv @@
`timescale 1ns / 1ps

module mrwt_ctrl import mrwt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.trivial) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = VERDICT_TRIVIAL;
          state_next     = S_FINISH;
        end else if (status.bad_wit) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = VERDICT_BAD_WIT;
          state_next     = S_FINISH;
        end else begin
          state_next = S_SPLIT;
        end
      end
      // Strip trailing zeros of n-1, one per cycle.
      S_SPLIT: begin
        if (!status.e_lsb) begin
          cmd.split_step = 1'b1;
        end else begin
          cmd.pow_init = 1'b1;
          state_next   = S_EXP_BIT;
        end
      end
      // Right-to-left square and multiply over the odd part.
      S_EXP_BIT: begin
        if (status.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_ACC_SQ;
          state_next    = S_WAIT_A;
        end else begin
          state_next = S_EXP_NEXT;
        end
      end
      S_WAIT_A: begin
        if (!status.mul_busy) begin
          state_next = S_EXP_NEXT;
        end
      end
      S_EXP_NEXT: begin
        if (status.e_done) begin
          state_next = S_TEST_X;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_SQ_SQ;
          cmd.e_shift   = 1'b1;
          state_next    = S_WAIT_S;
        end
      end
      S_WAIT_S: begin
        if (!status.mul_busy) begin
          state_next = S_EXP_BIT;
        end
      end
      S_TEST_X: begin
        if (status.x_one || status.x_nm1) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = VERDICT_PRIME;
          state_next     = S_FINISH;
        end else begin
          state_next = S_SQ_LOOP;
        end
      end
      // Up to k-1 further squarings looking for n-1.
      S_SQ_LOOP: begin
        if (status.k_le1) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = VERDICT_COMPOSITE;
          state_next     = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_ACC_ACC;
          cmd.k_dec     = 1'b1;
          state_next    = S_WAIT_X;
        end
      end
      S_WAIT_X: begin
        if (!status.mul_busy) begin
          state_next = S_TEST_SQ;
        end
      end
      S_TEST_SQ: begin
        if (status.x_nm1) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = VERDICT_PRIME;
          state_next     = S_FINISH;
        end else if (status.x_one) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = VERDICT_COMPOSITE;
          state_next     = S_FINISH;
        end else begin
          state_next = S_SQ_LOOP;
        end
      end
      // Hand the verdict to the output register once it is free.
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // No multiplication is left running when a new item can be taken.
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !status.mul_busy)
    else $error("multiplier busy while idle");

  // Entering a wait state always follows a started multiplication.
  assert property (@(posedge clk) disable iff (rst)
    (state != $past(state) && (state == S_WAIT_A || state == S_WAIT_S || state == S_WAIT_X))
      |-> status.mul_busy)
    else $error("wait state entered without a multiplication");

  // Loading a result always returns the controller to idle.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |=> (state == S_IDLE))
    else $error("controller did not return to idle after a result");
`endif

endmodule

@@ test/tb_miller_rabin_witness_test.sv @@
`timescale 1ns / 1ps

module tb_miller_rabin_witness_test;
  import mrwt_pkg::*;

  localparam int NUM_WIDTH    = 32;
  localparam int RANDOM_ITEMS = 267;
  // Receiver hold-off, long enough for the block to fill up and stall its input.
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 3000;
  // Window of results in which neither side idles.
  localparam int BURST_FIRST  = 150;
  localparam int BURST_LAST   = 200;
  // Sized for the worst item, about 2 * NUM_WIDTH products.
  localparam int DRAIN_CYCLES = 2 * NUM_WIDTH * (NUM_WIDTH + 3) + 100;

  // One test item as offered to the block; drain holds it back until the block is empty.
  typedef struct {
    logic [CAND_WIDTH-1:0] candidate;
    logic [WIT_WIDTH-1:0]  witness;
    bit                    drain;
  } trial_t;

  // Expected verdict, kept with the operands for reporting.
  typedef struct {
    logic [CAND_WIDTH-1:0] candidate;
    logic [WIT_WIDTH-1:0]  witness;
    verdict_t              verdict;
  } verdict_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trial_t       trial_q[$];
  verdict_rec_t verdict_q[$];
  int unsigned  n_sent = 0;
  int unsigned  n_done = 0;
  int unsigned  mismatches = 0;

  // Candidates that are primes, strong pseudoprimes to base two, or Carmichael numbers.
  int unsigned notable_n [0:19] = '{
    32'd3, 32'd5, 32'd7, 32'd13, 32'd97, 32'd65537, 32'd2147483647, 32'd4294967291,
    32'd4294967279, 32'd1000000007, 32'd999999937, 32'd2047, 32'd3277, 32'd4033,
    32'd4681, 32'd561, 32'd1105, 32'd1729, 32'd25326001, 32'd3215031751
  };

  mrwt_in_if  in_ch ();
  mrwt_out_if out_ch ();

  miller_rabin_witness_test #(
    .NUM_WIDTH(NUM_WIDTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // One round of the strong probable-prime test on the low NUM_WIDTH bits.
  function automatic verdict_t mr_verdict(logic [CAND_WIDTH-1:0] cand,
                                          logic [WIT_WIDTH-1:0] wit);
    logic [63:0] num_mask;
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] odd;
    logic [63:0] e;
    logic [63:0] acc;
    logic [63:0] sq;
    int          k;
    int          j;
    num_mask = (64'd1 << NUM_WIDTH) - 64'd1;
    n = 64'(cand) & num_mask;
    a = 64'(wit) & num_mask;
    if (n < 64'd2 || (n != 64'd2 && n[0] == 1'b0)) return VERDICT_TRIVIAL;
    if (a == 64'd0 || a >= n) return VERDICT_BAD_WIT;
    // Split n-1 into an odd part and a power of two.
    odd = n - 64'd1;
    k = 0;
    while (odd != 64'd0 && odd[0] == 1'b0) begin
      odd = odd >> 1;
      k++;
    end
    // Square-and-multiply for a^odd mod n; products stay below 2^64.
    acc = 64'd1 % n;
    sq = a % n;
    e = odd;
    while (e != 64'd0) begin
      if (e[0]) acc = (acc * sq) % n;
      sq = (sq * sq) % n;
      e = e >> 1;
    end
    if (acc == 64'd1 || acc == n - 64'd1) return VERDICT_PRIME;
    // Only squares below the full exponent may hit n-1.
    for (j = 1; j < k; j++) begin
      acc = (acc * acc) % n;
      if (acc == n - 64'd1) return VERDICT_PRIME;
      if (acc == 64'd1) return VERDICT_COMPOSITE;
    end
    return VERDICT_COMPOSITE;
  endfunction

  // Random odd number of exactly the given bit length, at least two bits.
  function automatic logic [31:0] odd_cand(int unsigned bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    return (32'($urandom) & m[31:0]) | 32'd1 | (32'd1 << (bits - 1));
  endfunction

  function automatic void add_trial(logic [31:0] cand, logic [31:0] wit, bit drain);
    trial_t t;
    t.candidate = cand;
    t.witness = wit;
    t.drain = drain;
    trial_q.push_back(t);
  endfunction

  // Driver: offers queued items, records the expected verdict of each accepted one.
  always @(posedge clk) begin : drive_proc
    int unsigned  sent_now;
    bit           gap;
    trial_t       nxt;
    verdict_rec_t rec;
    if (rst) begin
      in_ch.valid <= 1'b0;
      n_sent <= 0;
    end else begin
      sent_now = n_sent;
      if (in_ch.valid && in_ch.ready) begin
        rec.candidate = in_ch.candidate;
        rec.witness = in_ch.witness;
        rec.verdict = mr_verdict(in_ch.candidate, in_ch.witness);
        verdict_q.push_back(rec);
        sent_now = n_sent + 1;
        n_sent <= sent_now;
      end
      if (!in_ch.valid || in_ch.ready) begin
        gap = ($urandom_range(99) < 33) && !(n_sent >= BURST_FIRST && n_sent < BURST_LAST);
        if (trial_q.size() != 0 && !gap && !(trial_q[0].drain && sent_now != n_done)) begin
          nxt = trial_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.candidate <= nxt.candidate;
          in_ch.witness <= nxt.witness;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each verdict item against the oldest expectation.
  always @(posedge clk) begin : check_proc
    int unsigned  hold_left;
    bit           hold_done;
    verdict_rec_t rec;
    if (rst) begin
      out_ch.ready <= 1'b0;
      n_done <= 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_done <= n_done + 1;
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected verdict item, expected none, got %0d", $time,
                   out_ch.verdict);
        end else begin
          rec = verdict_q.pop_front();
          if (out_ch.verdict !== rec.verdict) begin
            mismatches++;
            $display("%0t: candidate %0d witness %0d: verdict expected %0d (%s), got %0d",
                     $time, rec.candidate, rec.witness, rec.verdict, rec.verdict.name(),
                     out_ch.verdict);
          end
        end
      end
      // One long hold-off while the sender keeps offering items.
      if (!hold_done && n_done == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(($urandom_range(99) < 33) &&
                          !(n_done >= BURST_FIRST && n_done < BURST_LAST));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned w;
    int          i;
    in_ch.valid = 1'b0;
    in_ch.candidate = '0;
    in_ch.witness = '0;
    out_ch.ready = 1'b0;

    // Trivial candidates: zero, one, even ones, whatever the witness.
    add_trial(32'd0, 32'd5, 1'b0);
    add_trial(32'd1, 32'hFFFFFFFF, 1'b0);
    add_trial(32'd4, 32'd1, 1'b0);
    add_trial(32'hFFFFFFFE, 32'd3, 1'b0);
    // Candidate two: only witness one is valid.
    add_trial(32'd2, 32'd1, 1'b0);
    add_trial(32'd2, 32'd0, 1'b0);
    add_trial(32'd2, 32'd2, 1'b0);
    // Witness zero, equal to the candidate, and far above it.
    add_trial(32'd3, 32'd0, 1'b0);
    add_trial(32'd3, 32'd3, 1'b0);
    add_trial(32'd9, 32'hFFFFFFFF, 1'b0);
    add_trial(32'd3, 32'd1, 1'b0);
    add_trial(32'd3, 32'd2, 1'b0);
    // Largest 32-bit prime and the all-ones composite, with extreme witnesses.
    add_trial(32'd4294967291, 32'd2, 1'b0);
    add_trial(32'd4294967291, 32'd4294967290, 1'b0);
    add_trial(32'hFFFFFFFF, 32'd2, 1'b0);
    add_trial(32'hFFFFFFFF, 32'hFFFFFFFE, 1'b0);
    // Strong liars, and composites caught when a square reaches one.
    add_trial(32'd2047, 32'd2, 1'b0);
    add_trial(32'd25, 32'd7, 1'b0);
    add_trial(32'd561, 32'd2, 1'b0);
    add_trial(32'd341, 32'd2, 1'b0);
    add_trial(32'd97, 32'd1, 1'b0);
    add_trial(32'd97, 32'd96, 1'b0);
    add_trial(32'd3215031751, 32'd2, 1'b0);

    // Mostly valid witnesses on odd candidates, with some rejects mixed in.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1) : ($urandom & ~32'd1);
        w = $urandom;
      end else if (pick < 20) begin
        n = odd_cand($urandom_range(32, 2));
        case ($urandom_range(2))
          0: w = 32'd0;
          1: w = n;
          default: w = $urandom_range(32'hFFFFFFFF, n);
        endcase
      end else begin
        if (pick < 35) n = notable_n[$urandom_range(19)];
        else if (pick < 65) n = odd_cand($urandom_range(12, 2));
        else n = odd_cand($urandom_range(32, 13));
        w = $urandom_range(n - 1, 1);
      end
      add_trial(n, w, (i == 0 || i == 100 || i == 200));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (trial_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (n_done != n_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(64'd60_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
